// ----- rtl/sprite_list_walker_assert.svh -----
// Assertion macros used by the sprite list walker back end (slw_back).
`ifndef SPRITE_LIST_WALKER_ASSERT_SVH
`define SPRITE_LIST_WALKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/slw_pkg.sv -----
// Shared types and constants of the sprite list walker.
package slw_pkg;

  localparam int SPRITE_SLOTS_DEF = 24;
  localparam int ROW_W = 6;
  localparam int LANE_W = 2;
  localparam int LANES = 4;
  localparam int STORE_ROWS = 64;
  localparam int QDEPTH = 4;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_WALK = 1'b1;

  localparam logic REG_FLIP_SCREEN = 1'b0;

  localparam logic [7:0] Y_LOW = 8'd3;
  localparam logic [7:0] Y_HIGH = 8'hfc;
  localparam logic [8:0] X_OFS = 9'd7;
  localparam logic [8:0] X_FLIP_BASE = 9'd233;
  localparam logic [8:0] Y_BASE = 9'd225;
  localparam logic [8:0] Y_FLIP_OFS = 9'd15;

  typedef struct packed {
    logic is_walk;
    logic [ROW_W-1:0] row;
    logic [LANE_W-1:0] lane;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tile_code;
    logic [8:0] screen_x;
    logic [8:0] screen_y;
    logic [3:0] palette_sel;
    logic mirror_x;
    logic mirror_y;
    logic visible;
    logic last;
  } draw_t;

endpackage

// ----- rtl/slw_front.sv -----
// Input side: classifies incoming words and queues them for the walker.
module slw_front (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,
  input  logic s_tuser,
  output logic cmd_valid,
  input  logic cmd_ready,
  output slw_pkg::cmd_t cmd
);

  localparam int PW = $clog2(slw_pkg::QDEPTH);

  slw_pkg::cmd_t slots [slw_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  logic push;
  logic pop;
  slw_pkg::cmd_t incoming;

  assign s_tready = (count != (PW+1)'(slw_pkg::QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd = slots[rd_ptr];
  assign push = s_tvalid && s_tready;
  assign pop = cmd_valid && cmd_ready;

  always_comb begin
    incoming.is_walk = (s_tuser == slw_pkg::KIND_WALK);
    incoming.lane = s_tdata[slw_pkg::LANE_W-1:0];
    incoming.row = s_tdata[7:slw_pkg::LANE_W];
    incoming.data = s_tdata[15:8];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/slw_back.sv -----
// Execution side: sprite store, list walk and draw command output register.
`include "sprite_list_walker_assert.svh"

module slw_back #(
  parameter int SPRITE_SLOTS = slw_pkg::SPRITE_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic flip_screen,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  slw_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output slw_pkg::draw_t out_draw
);

  localparam int KW = $clog2(SPRITE_SLOTS + 1);
  localparam int RW = slw_pkg::ROW_W;

  logic walking;
  logic [KW-1:0] k;
  logic s1_valid;
  logic s1_last;
  logic advance;
  logic issue;
  logic wr_en;
  logic start;
  logic [RW-1:0] rd_row;
  logic [7:0] rd_data [slw_pkg::LANES];
  logic [slw_pkg::LANES-1:0] rd_vld;
  logic [7:0] raw_y;
  logic [7:0] raw_code;
  logic [7:0] raw_attr;
  logic [7:0] raw_x;
  slw_pkg::draw_t draw_next;

  assign cmd_ready = !walking;
  assign wr_en = cmd_valid && cmd_ready && !cmd.is_walk;
  assign start = cmd_valid && cmd_ready && cmd.is_walk;
  assign advance = !out_valid || out_ready;
  assign issue = walking && (!s1_valid || advance);
  assign rd_row = (k == KW'(1)) ? RW'(SPRITE_SLOTS - 1) : RW'(k - KW'(2));

  for (genvar l = 0; l < slw_pkg::LANES; l++) begin : g_lane
    logic [7:0] mem [slw_pkg::STORE_ROWS];
    logic [slw_pkg::STORE_ROWS-1:0] vld;

    always_ff @(posedge clk) begin
      if (wr_en && cmd.lane == slw_pkg::LANE_W'(l)) begin
        mem[cmd.row] <= cmd.data;
      end
      if (issue) begin
        rd_data[l] <= mem[rd_row];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= '0;
        rd_vld[l] <= 1'b0;
      end else begin
        if (wr_en && cmd.lane == slw_pkg::LANE_W'(l)) begin
          vld[cmd.row] <= 1'b1;
        end
        if (issue) begin
          rd_vld[l] <= vld[rd_row];
        end
      end
    end
  end

  assign raw_y = rd_vld[0] ? rd_data[0] : 8'd0;
  assign raw_code = rd_vld[1] ? rd_data[1] : 8'd0;
  assign raw_attr = rd_vld[2] ? rd_data[2] : 8'd0;
  assign raw_x = rd_vld[3] ? rd_data[3] : 8'd0;

  always_comb begin
    draw_next = '0;
    draw_next.last = s1_last;
    if (raw_y >= slw_pkg::Y_LOW && raw_y <= slw_pkg::Y_HIGH) begin
      draw_next.visible = 1'b1;
      draw_next.tile_code = raw_code;
      draw_next.palette_sel = raw_attr[3:0];
      draw_next.mirror_x = raw_attr[6] ^ flip_screen;
      draw_next.mirror_y = raw_attr[7] ^ flip_screen;
      if (flip_screen) begin
        draw_next.screen_x = slw_pkg::X_FLIP_BASE - {1'b0, raw_x};
        draw_next.screen_y = {1'b0, raw_y} - slw_pkg::Y_FLIP_OFS;
      end else begin
        draw_next.screen_x = {1'b0, raw_x} - slw_pkg::X_OFS;
        draw_next.screen_y = slw_pkg::Y_BASE - {1'b0, raw_y};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_draw <= draw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      k <= '0;
      s1_valid <= 1'b0;
      s1_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        walking <= 1'b1;
        k <= KW'(SPRITE_SLOTS);
      end else if (issue) begin
        k <= k - KW'(1);
        if (k == KW'(1)) begin
          walking <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
        s1_last <= (k == KW'(1));
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  `SLW_ASSERT_NOW(a_walk_count, clk, rst, walking, k != '0, "walk active with no entries left")
  `SLW_ASSERT_NEXT(a_walk_end, clk, rst, issue && k == KW'(1), !walking, "walk did not end after final entry")
  `SLW_ASSERT_NEXT(a_stage_hold, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_last), "read stage lost an entry under stall")

endmodule

// ----- rtl/sprite_list_walker.sv -----
// Top level of the sprite list walker: ports, register file and submodules.
//
// The input channel carries one word per cycle while tready is high: tuser low
// selects a store byte write (tdata holds address, then data), tuser high
// starts a list walk. A walk emits SPRITE_SLOTS draw commands on the output
// channel, entries SPRITE_SLOTS-2 down to 0 and then the top entry; the final
// one has tlast set. Store writes produce no output word. A walk reads one
// sprite store row per command, and each command passes the read stage and
// then the output register. A four-word queue sits between input and walker,
// so writes keep arriving while a walk is in progress. When the receiver
// stalls, the output register and one read stage hold their commands and the
// walk pauses; the queue then fills and the input deasserts tready. Reset
// clears the sprite store, the queue and the flip_screen register. The user
// must write flip_screen over the APB port (paddr[2] low, so addresses 0 to 3)
// only while the block is idle; the block does not enforce this.
module sprite_list_walker #(
  parameter int SPRITE_SLOTS = slw_pkg::SPRITE_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,  // byte_addr[7:0], byte_data[15:8]
  input  logic s_tuser,         // kind
  output logic m_tvalid,
  input  logic m_tready,
  // tile_code[7:0], screen_x[16:8], screen_y[25:17], palette_sel[29:26],
  // mirror_x[30], mirror_y[31], visible[32], zero[39:33]
  output logic [slw_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tlast,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [slw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic flip_screen;
  logic cmd_valid;
  logic cmd_ready;
  slw_pkg::cmd_t cmd;
  slw_pkg::draw_t out_draw;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == slw_pkg::REG_FLIP_SCREEN) ? {31'd0, flip_screen} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_screen <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == slw_pkg::REG_FLIP_SCREEN) begin
      flip_screen <= pwdata[0];
    end
  end

  slw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  slw_back #(
    .SPRITE_SLOTS(SPRITE_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .flip_screen(flip_screen),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_draw   (out_draw)
  );

  assign m_tdata = {7'd0, out_draw.visible, out_draw.mirror_y, out_draw.mirror_x,
                    out_draw.palette_sel, out_draw.screen_y, out_draw.screen_x,
                    out_draw.tile_code};
  assign m_tlast = out_draw.last;

endmodule
